/* hw/rtl/bgc_pkg.sv */
package bgc_pkg;

  localparam int MAX_VERTICES_DEF   = 16;
  localparam int MAX_COLORS_DEF     = 16;
  localparam int MOMENTUM_WIDTH_DEF = 40;

  localparam int ROW_W      = 16;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int PEN_W      = 13;
  localparam int ENERGY_W   = 29;
  localparam int ITER_W     = 21;
  localparam int K_W        = 7;
  localparam int SCALE_W    = 32;
  localparam int PROD_W     = SCALE_W + K_W + 1;

  typedef enum logic [1:0] {
    CMD_LOAD_ADJ  = 2'd0,
    CMD_LOAD_SPIN = 2'd1,
    CMD_RUN       = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT   = 3'd0,
    CFG_COLOR_COUNT    = 3'd1,
    CFG_MAX_ITERATIONS = 3'd2,
    CFG_TIME_STEP      = 3'd3,
    CFG_PENALTY_WEIGHT = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SNAP,
    ST_RD,
    ST_MUL,
    ST_WR,
    ST_ENER,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [3:0]       vertex;
    logic [ROW_W-1:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          out_vertex;
    logic [ROW_W-1:0]    color_bits;
    logic [ENERGY_W-1:0] energy;
    logic [ITER_W-1:0]   iterations_done;
    logic                last;
  } result_t;

  typedef struct packed {
    logic mul_en;
    logic load_en;
  } upd_ctl_t;

  function automatic logic [CNT_W-1:0] popcount16(input logic [ROW_W-1:0] x);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int b = 0; b < ROW_W; b++) begin
      n = n + CNT_W'(x[b]);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/bgc_mom_ram.sv */
module bgc_mom_ram #(
  parameter int AW = 8,
  parameter int DW = 40
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [1<<AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/bgc_upd.sv */
module bgc_upd #(
  parameter int MW = bgc_pkg::MOMENTUM_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  bgc_pkg::upd_ctl_t            ctl_i,
  input  logic [bgc_pkg::SCALE_W-1:0]  scale_i,
  input  logic signed [bgc_pkg::K_W-1:0] k_i,
  input  logic                         mom_valid_i,
  input  logic [MW-1:0]                mom_i,
  output logic signed [MW-1:0]         mom_new_o
);

  import bgc_pkg::*;

  localparam int SW = ((MW > PROD_W) ? MW : PROD_W) + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [MW-1:0]     mom_q;
  logic signed [SW-1:0]     diff;
  logic signed [SW-1:0]     maxv;
  logic signed [SW-1:0]     minv;

  // registered product scale*k, then saturating subtract
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= $signed({1'b0, scale_i}) * k_i;
    end
    if (ctl_i.load_en) begin
      mom_q <= mom_valid_i ? $signed(mom_i) : '0;
    end
  end

  always_comb begin
    maxv = SW'({1'b0, {(MW-1){1'b1}}});
    minv = -maxv - SW'(1);
    diff = SW'(mom_q) - SW'(prod_q);
    if (diff > maxv) begin
      mom_new_o = maxv[MW-1:0];
    end else if (diff < minv) begin
      mom_new_o = minv[MW-1:0];
    end else begin
      mom_new_o = diff[MW-1:0];
    end
  end

endmodule

/* hw/rtl/bifurcation_graph_coloring_solver_top.sv */
// Graph coloring solver by discrete simulated bifurcation. Load items (adjacency
// or spin row) are written while idle. A run item walks every vertex/color entry
// per iteration through one shared momentum update unit, with a read, multiply
// and write step per entry, and a run takes at most max_iterations iterations
// before its nv results are output. busy is high for the whole
// run. Results come out one per cycle, vertex 0 first, flagged by res_valid_o;
// the receiver cannot stall, so it must take each result in the cycle shown.
module bifurcation_graph_coloring_solver_top #(
  parameter int MAX_VERTICES   = bgc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_COLORS     = bgc_pkg::MAX_COLORS_DEF,
  parameter int MOMENTUM_WIDTH = bgc_pkg::MOMENTUM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bgc_pkg::in_item_t             in_item_i,
  input  logic                          cfg_we_i,
  input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bgc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                          res_valid_o,
  output bgc_pkg::result_t              res_o
);

  import bgc_pkg::*;

  localparam int NVL   = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int NCL   = (MAX_COLORS < ROW_W) ? MAX_COLORS : ROW_W;
  localparam int VW    = $clog2(NVL);
  localparam int CW    = (NCL > 1) ? $clog2(NCL) : 1;
  localparam int AW    = VW + CW;

  // configuration
  logic [CNT_W-1:0]   vc_q, cc_q;
  logic [ITER_W-1:0]  max_iter_q;
  logic [ROW_W-1:0]   ts_q, pw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q       <= CNT_W'(16);
      cc_q       <= CNT_W'(2);
      max_iter_q <= ITER_W'(20000);
      ts_q       <= ROW_W'(205);
      pw_q       <= ROW_W'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VERTEX_COUNT:   vc_q       <= cfg_wdata_i[CNT_W-1:0];
        CFG_COLOR_COUNT:    cc_q       <= cfg_wdata_i[CNT_W-1:0];
        CFG_MAX_ITERATIONS: max_iter_q <= cfg_wdata_i[ITER_W-1:0];
        CFG_TIME_STEP:      ts_q       <= cfg_wdata_i[ROW_W-1:0];
        CFG_PENALTY_WEIGHT: pw_q       <= cfg_wdata_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] nv, nc;
  logic [ROW_W-1:0] vmask, cmask;

  always_comb begin
    if (vc_q == '0) nv = CNT_W'(1);
    else if (int'(vc_q) > NVL) nv = CNT_W'(NVL);
    else nv = vc_q;
    if (cc_q == '0) nc = CNT_W'(1);
    else if (int'(cc_q) > NCL) nc = CNT_W'(NCL);
    else nc = cc_q;
    vmask = ROW_W'((17'(1) << nv) - 17'(1));
    cmask = ROW_W'((17'(1) << nc) - 17'(1));
  end

  // state
  state_e state_q, state_d;
  logic [ROW_W-1:0]    adj_q  [NVL];
  logic [ROW_W-1:0]    spin_q [NVL];
  logic [ROW_W-1:0]    bits_q [NVL];
  logic                vld_rd_q;
  logic [VW-1:0]       i_q;
  logic [CW-1:0]       c_q;
  logic [ITER_W-1:0]   iter_q;
  logic [PEN_W-1:0]    pen_q;
  logic [ENERGY_W-1:0] energy_q;
  logic [SCALE_W-1:0]  scale_q;
  logic signed [K_W-1:0] k_q;

  logic accept;
  logic [AW-1:0] addr;
  logic [ROW_W-1:0] col, nb, own;
  logic [CNT_W-1:0] n, s, dv;
  logic [9:0] dv2;
  logic signed [K_W-1:0] k_d;
  logic [PEN_W-1:0] pen_add;
  logic last_c, last_i;
  logic [MOMENTUM_WIDTH-1:0] mom_rd;
  logic signed [MOMENTUM_WIDTH-1:0] mom_new;
  upd_ctl_t upd_ctl;
  logic mom_we;

  assign accept = start && !busy;
  assign addr   = {i_q, c_q};
  assign own    = bits_q[i_q];
  assign nb     = adj_q[i_q] & vmask;
  assign last_c = (CNT_W'(c_q) + CNT_W'(1)) == nc;
  assign last_i = (CNT_W'(i_q) + CNT_W'(1)) == nv;

  always_comb begin
    col = '0;
    for (int v = 0; v < NVL; v++) begin
      col[v] = bits_q[v][c_q];
    end
    n   = popcount16(nb & col);
    s   = popcount16(own);
    dv  = (s > CNT_W'(1)) ? s - CNT_W'(1) : CNT_W'(1) - s;
    dv2 = 10'(dv) * 10'(dv);
    k_d = $signed(K_W'({s, 1'b0})) + $signed(K_W'(n)) - $signed(K_W'(2));
    pen_add = ((c_q == '0) ? PEN_W'(dv2) : '0) + (own[c_q] ? PEN_W'(n) : '0);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    upd_ctl = '0;
    mom_we  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_item_i.command == CMD_RUN) begin
          state_d = (max_iter_q == '0) ? ST_OUT : ST_SNAP;
        end
      end
      ST_SNAP: state_d = ST_RD;
      ST_RD:   state_d = ST_MUL;
      ST_MUL: begin
        upd_ctl.mul_en  = 1'b1;
        upd_ctl.load_en = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        mom_we  = 1'b1;
        state_d = (last_c && last_i) ? ST_ENER : ST_RD;
      end
      ST_ENER: begin
        state_d = (pen_q == '0 || (iter_q + ITER_W'(1)) >= max_iter_q) ? ST_OUT : ST_SNAP;
      end
      ST_OUT:  state_d = last_i ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NVL; v++) begin
        adj_q[v]  <= '0;
        spin_q[v] <= '0;
      end
      vld_rd_q <= 1'b0;
      i_q      <= '0;
      c_q      <= '0;
      iter_q   <= '0;
      pen_q    <= '0;
      energy_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            priority case (in_item_i.command)
              CMD_LOAD_ADJ: begin
                if (int'(in_item_i.vertex) < NVL) adj_q[VW'(in_item_i.vertex)] <= in_item_i.row_bits;
              end
              CMD_LOAD_SPIN: begin
                if (int'(in_item_i.vertex) < NVL) spin_q[VW'(in_item_i.vertex)] <= in_item_i.row_bits;
              end
              CMD_RUN: begin
                iter_q   <= '0;
                energy_q <= '0;
                i_q      <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SNAP: begin
          for (int v = 0; v < NVL; v++) begin
            bits_q[v] <= spin_q[v] & cmask;
          end
          pen_q <= '0;
          i_q   <= '0;
          c_q   <= '0;
        end
        ST_RD: begin
          k_q      <= k_d;
          pen_q    <= pen_q + pen_add;
          // the first sweep writes every entry in use, so momenta read as zero until then
          vld_rd_q <= (iter_q != '0);
        end
        ST_MUL: ;
        ST_WR: begin
          if (!mom_new[MOMENTUM_WIDTH-1] && (mom_new != '0)) begin
            spin_q[i_q][c_q] <= 1'b1;
          end else if (mom_new[MOMENTUM_WIDTH-1]) begin
            spin_q[i_q][c_q] <= 1'b0;
          end
          if (last_c) begin
            c_q <= '0;
            i_q <= i_q + VW'(1);
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
        ST_ENER: begin
          energy_q <= ENERGY_W'(pen_q) * ENERGY_W'(pw_q);
          iter_q   <= iter_q + ITER_W'(1);
          i_q      <= '0;
        end
        ST_OUT: i_q <= i_q + VW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.command == CMD_RUN) begin
      scale_q <= SCALE_W'(ts_q) * SCALE_W'(pw_q);
    end
  end

  bgc_mom_ram #(
    .AW (AW),
    .DW (MOMENTUM_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mom_we),
    .waddr_i (addr),
    .wdata_i (mom_new),
    .raddr_i (addr),
    .rdata_o (mom_rd)
  );

  bgc_upd #(
    .MW (MOMENTUM_WIDTH)
  ) u_upd (
    .clk_i       (clk_i),
    .ctl_i       (upd_ctl),
    .scale_i     (scale_q),
    .k_i         (k_q),
    .mom_valid_i (vld_rd_q),
    .mom_i       (mom_rd),
    .mom_new_o   (mom_new)
  );

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);

  always_comb begin
    res_o                 = '0;
    res_o.out_vertex      = 4'(i_q);
    res_o.color_bits      = spin_q[i_q] & cmask;
    res_o.energy          = energy_q;
    res_o.iterations_done = iter_q;
    res_o.last            = last_i;
  end

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result outside run");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o) else $error("result after last");

  a_wr_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> ($past(state_q) == ST_MUL)) else $error("write without product");

  a_rd_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_MUL)) else $error("read not followed by multiply");

endmodule
